[src/rgbp_pkg.sv]
package rgbp_pkg;

  localparam int CHAN_W      = 16;
  localparam int CHAN_KEEP   = 12;
  localparam int PIX_BITS    = 3 * CHAN_KEEP;
  localparam int WORD_W      = 32;
  localparam int ACC_W       = 2 * WORD_W;
  localparam int PHASE_W     = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PHASE_W-1:0] LAST_PHASE = '1;
  localparam logic BYTE_ORDER_RESET = 1'b1;

  // One queue entry: everything a pixel sends out, as packed (little-endian).
  typedef struct packed {
    logic [WORD_W-1:0] word_lo;
    logic [WORD_W-1:0] word_hi;
    logic              two;
  } pair_t;

  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

[src/rgbp_ifs.sv]
interface rgbp_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] alpha;
  logic        line_end;

  modport source(output valid, red, green, blue, alpha, line_end, input ready);
  modport sink(input valid, red, green, blue, alpha, line_end, output ready);
endinterface

interface rgbp_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last_of_run;

  modport source(output valid, word, last_of_run, input ready);
  modport sink(input valid, word, last_of_run, output ready);
endinterface

interface rgbp_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[src/rgba16_to_rgb12_word_packer.sv]
// Packs RGBA pixels with 16-bit channels into a stream of 32-bit words. Each
// pixel keeps bits 15..4 of red, green and blue (alpha is dropped), and the
// 36 bits are appended LSB first, red lowest, to a bit stream that leaves as
// words: in a group of eight pixels the first seven complete one word each and
// the eighth completes two, and last_of_run marks the final word a pixel
// caused. A pixel with line_end set still sends its words, after which any
// partial residue is dropped and the next pixel starts a new group. The
// byte_order register (reset 1) swaps the four bytes of every word when set
// and leaves words as packed when clear; write it only while the block is idle.
// The input takes a pixel every cycle while the two-entry queue between the
// packing front and the output stage has room. The eighth pixel of a group
// yields two words and so holds the output stage longer than the others;
// sustained throughput is set by the single output word register. When the
// queue and the output register are empty, the first word of a pixel passes
// through a queue slot and then the output word register before it is valid.
module rgba16_to_rgb12_word_packer #(
  parameter int QUEUE_DEPTH = rgbp_pkg::QUEUE_DEPTH
) (
  input logic         clk,
  input logic         rst_n,
  rgbp_pix_if.sink    in_pix,
  rgbp_cfg_if.sink    cfg_wr,
  rgbp_word_if.source out_word
);

  // Front to queue: one entry per accepted pixel, holding one or two words.
  logic            push_valid;
  logic            push_ready;
  rgbp_pkg::pair_t push_entry;

  // Queue to back.
  logic            q_valid;
  logic            q_pop;
  rgbp_pkg::pair_t q_entry;

  // The front owns the packing phase and residue and updates them on accept.
  rgbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // The queue lets the front keep taking pixels while the back sends the
  // second word of a pair or waits on a stalled sink.
  rgbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_entry (push_entry),
    .wr_ready (push_ready),
    .rd_valid (q_valid),
    .rd_entry (q_entry),
    .rd_pop   (q_pop)
  );

  // The back holds the byte-order register, splits pairs into single words
  // and applies the byte swap at the output register.
  rgbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .out_word (out_word)
  );

endmodule

[src/rgbp_front.sv]
module rgbp_front (
  input  logic                clk,
  input  logic                rst_n,
  rgbp_pix_if.sink            in_pix,
  output logic                push_valid,
  output rgbp_pkg::pair_t     push_entry,
  input  logic                push_ready
);

  logic [rgbp_pkg::WORD_W-1:0]   residue_r, residue_nxt;
  logic [rgbp_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [rgbp_pkg::PIX_BITS-1:0] pix;
  logic [rgbp_pkg::ACC_W-1:0]    acc;
  logic                          accept;
  logic                          group_end;

  assign in_pix.ready = push_ready;
  assign push_valid   = in_pix.valid;
  assign accept       = in_pix.valid && push_ready;
  assign group_end    = (phase_r == rgbp_pkg::LAST_PHASE);

  // Red lands in the lowest bits, blue in the highest.
  assign pix = {in_pix.blue[15:4], in_pix.green[15:4], in_pix.red[15:4]};
  assign acc = {{rgbp_pkg::WORD_W{1'b0}}, residue_r}
             | ({{(rgbp_pkg::ACC_W - rgbp_pkg::PIX_BITS){1'b0}}, pix} << {phase_r, 2'b00});

  assign push_entry.word_lo = acc[rgbp_pkg::WORD_W-1:0];
  assign push_entry.word_hi = acc[rgbp_pkg::ACC_W-1:rgbp_pkg::WORD_W];
  assign push_entry.two     = group_end;

  always_comb begin
    residue_nxt = residue_r;
    phase_nxt   = phase_r;
    if (accept) begin
      if (in_pix.line_end || group_end) begin
        residue_nxt = '0;
      end else begin
        residue_nxt = acc[rgbp_pkg::ACC_W-1:rgbp_pkg::WORD_W];
      end
      phase_nxt = in_pix.line_end ? '0 : phase_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      residue_r <= '0;
      phase_r   <= '0;
    end else begin
      residue_r <= residue_nxt;
      phase_r   <= phase_nxt;
    end
  end

  // A line end always restarts the packing from an empty residue.
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_pix.line_end |=> phase_r == '0 && residue_r == '0)
    else $error("line end did not clear packing state");

  // Only the low four bits per pending pixel may be set in the residue.
  a_residue_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (residue_r >> {phase_r, 2'b00}) == '0)
    else $error("residue holds bits beyond the current phase");

endmodule

[src/rgbp_queue.sv]
module rgbp_queue #(
  parameter int DEPTH = rgbp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  rgbp_pkg::pair_t wr_entry,
  output logic            wr_ready,
  output logic            rd_valid,
  output rgbp_pkg::pair_t rd_entry,
  input  logic            rd_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rgbp_pkg::pair_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_entry = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count overflow");

endmodule

[src/rgbp_back.sv]
module rgbp_back (
  input  logic            clk,
  input  logic            rst_n,
  rgbp_cfg_if.sink        cfg_wr,
  input  logic            q_valid,
  input  rgbp_pkg::pair_t q_entry,
  output logic            q_pop,
  rgbp_word_if.source     out_word
);

  logic                        byte_order_r, byte_order_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [rgbp_pkg::WORD_W-1:0] out_data_r, out_data_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        hi_pend_r, hi_pend_nxt;
  logic [rgbp_pkg::WORD_W-1:0] hi_word_r, hi_word_nxt;
  logic                        load;

  assign cfg_wr.ready         = 1'b1;
  assign out_word.valid       = out_valid_r;
  assign out_word.word        = out_data_r;
  assign out_word.last_of_run = out_last_r;

  assign load  = !out_valid_r || out_word.ready;
  assign q_pop = load && !hi_pend_r && q_valid;

  assign byte_order_nxt = cfg_wr.valid ? cfg_wr.data : byte_order_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    hi_pend_nxt   = hi_pend_r;
    hi_word_nxt   = hi_word_r;
    if (load) begin
      priority if (hi_pend_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = byte_order_r ? rgbp_pkg::swap_bytes(hi_word_r) : hi_word_r;
        out_last_nxt  = 1'b1;
        hi_pend_nxt   = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = byte_order_r ? rgbp_pkg::swap_bytes(q_entry.word_lo)
                                     : q_entry.word_lo;
        out_last_nxt  = !q_entry.two;
        hi_pend_nxt   = q_entry.two;
        hi_word_nxt   = q_entry.word_hi;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= rgbp_pkg::BYTE_ORDER_RESET;
      out_valid_r  <= 1'b0;
      hi_pend_r    <= 1'b0;
    end else begin
      byte_order_r <= byte_order_nxt;
      out_valid_r  <= out_valid_nxt;
      hi_pend_r    <= hi_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    hi_word_r  <= hi_word_nxt;
  end

  // While a second word waits, the first of the pair sits in the output register.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    hi_pend_r |-> out_valid_r && !out_last_r)
    else $error("second word pending without its first word shown");

  // The second word of a pair always follows with the run marker set.
  a_pair_closes: assert property (@(posedge clk) disable iff (!rst_n)
    hi_pend_r && out_word.ready |=> out_valid_r && out_last_r)
    else $error("second word of a pair not delivered next");

endmodule
